// File: rtl/segregated_free_list_allocator_core_macros.svh
// Assertion helpers for the allocator checker.
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SFLA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfla assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SFLA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfla assertion failed");

`endif

// File: rtl/sfla_pkg.sv
package sfla_pkg;

    localparam int ADDR_W = 20;
    localparam int STAT_W = 2;
    localparam int SIZE_W = 21;

    localparam logic [ADDR_W-1:0] MIN_SPLIT = 20'd32;
    localparam logic [ADDR_W-1:0] GROW_MIN  = 20'd144;
    localparam logic [ADDR_W-1:0] CAP_LIMIT = 20'hFFFF0;
    localparam logic [ADDR_W-1:0] PROLOGUE_TAG = 20'd17;
    localparam logic [ADDR_W-1:0] EPILOGUE_TAG = 20'd1;

    typedef enum logic {
        ACT_ALLOC,
        ACT_FREE
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE,
        STAT_NO_SPACE,
        STAT_NULL
    } status_t;

    typedef enum logic [5:0] {
        S_INIT,
        S_IDLE,
        S_DONE,
        A_HEAD,
        A_LINK,
        A_SIZE,
        G_CHK,
        G_EPI,
        PL_RS,
        PL_DEC,
        PL_T2,
        PL_AP,
        F_RS,
        F_ST,
        F_RN,
        F_RP,
        F_RPA,
        F_RNA,
        F_DEC,
        F_PS,
        F_PS2,
        F_NX,
        F_NS,
        F_NS2,
        F_WR,
        F_AP,
        F_AP2,
        ST_WH,
        ST_RH,
        ST_WF,
        UL_RP,
        UL_RN,
        UL_W1,
        UL_W2,
        AP_R,
        AP_W1,
        AP_W2,
        AP_W3,
        AP_W4
    } state_t;

    function automatic logic [ADDR_W-1:0] size_of(input logic [ADDR_W-1:0] w);
        return {w[ADDR_W-1:4], 4'b0000};
    endfunction

endpackage

// File: rtl/sfla_ifs.sv
interface sfla_req_if;
    import sfla_pkg::*;
    logic              valid;
    logic              ready;
    logic              action;
    logic [ADDR_W-1:0] req_size;
    logic [ADDR_W-1:0] block_addr;
    modport source (output valid, action, req_size, block_addr, input ready);
    modport sink (input valid, action, req_size, block_addr, output ready);
endinterface

interface sfla_rsp_if;
    import sfla_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_addr;
    logic [STAT_W-1:0] status;
    modport source (output valid, result_addr, status, input ready);
    modport sink (input valid, result_addr, status, output ready);
endinterface

// File: rtl/sfla_ram.sv
module sfla_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/segregated_free_list_allocator_core.sv
// Segregated-fit heap allocator over a boundary-tagged word memory. Each word on req is an
// allocate (action 0, req_size bytes) or a free (action 1, block_addr); each gives one word on
// rsp with result_addr and status. All heap state sits in one memory of HEAP_WORD_COUNT words
// (at most 131072) with one access per cycle, so time is set by that single port: an allocate
// scans class heads and free-list nodes, then does tag and link updates; a free takes longer
// the more neighbors merge. After reset an init pass writes the 4*CLASS_COUNT+4 words of the
// sentinels, prologue and epilogue; req stays not ready until it ends. A new word is taken
// while the previous result still waits on rsp.
module segregated_free_list_allocator_core #(
    parameter int HEAP_WORD_COUNT = 65536,
    parameter int CLASS_COUNT = 14
) (
    input  logic     clk,
    input  logic     rst_n,
    sfla_req_if.sink req,
    sfla_rsp_if.source rsp
);
    import sfla_pkg::*;

    localparam int MEM_DEPTH = (HEAP_WORD_COUNT < 131072) ? HEAP_WORD_COUNT : 131072;
    localparam int MAW = $clog2(MEM_DEPTH);
    localparam int CW = $clog2(CLASS_COUNT);
    localparam int BW = $clog2(HEAP_WORD_COUNT + 1);
    localparam int INIT_WORDS = 4 * CLASS_COUNT + 4;
    localparam int IW = $clog2(INIT_WORDS);
    localparam longint CAP_FULL = longint'(HEAP_WORD_COUNT) * 8;
    localparam logic [ADDR_W+1:0] CAP =
        (CAP_FULL > longint'(CAP_LIMIT)) ? (ADDR_W+2)'(CAP_LIMIT) : (ADDR_W+2)'(CAP_FULL);
    localparam logic [CW-1:0] CLS_LAST = CW'(CLASS_COUNT - 1);
    localparam logic [IW-1:0] INIT_LAST = IW'(INIT_WORDS - 1);
    localparam logic [IW-1:0] INIT_BASE = IW'(4 * CLASS_COUNT);
    localparam logic [ADDR_W-1:0] BRK_INIT = ADDR_W'(32 * CLASS_COUNT + 32);

    function automatic logic [CW-1:0] class_of(input logic [ADDR_W+1:0] s);
        logic [CW-1:0] c;
        c = '0;
        for (int j = 0; j < CLASS_COUNT - 1; j++)
        begin
            if ({10'd0, s} > (32'd64 << j))
            begin
                c = c + 1'b1;
            end
        end
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] head_of(input logic [CW-1:0] c);
        return ADDR_W'({c, 5'd8});
    endfunction

    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    logic [IW-1:0]     init_reg, init_next;
    logic [ADDR_W-1:0] brk_reg, brk_next;
    logic [BW-1:0]     budget_reg, budget_next;
    logic              out_valid_reg, out_valid_next;
    logic              oob_reg, oob_next;

    logic [ADDR_W-1:0] bp_reg, bp_next;
    logic [ADDR_W-1:0] nxt_reg, nxt_next;
    logic [ADDR_W-1:0] prv_reg, prv_next;
    logic [SIZE_W-1:0] asize_reg, asize_next;
    logic [ADDR_W-1:0] sz_reg, sz_next;
    logic [CW-1:0]     cls_reg, cls_next;
    logic [ADDR_W-1:0] t_bp_reg, t_bp_next;
    logic [ADDR_W-1:0] t_val_reg, t_val_next;
    logic [ADDR_W-1:0] t_head_reg, t_head_next;
    logic [ADDR_W-1:0] lk_p_reg, lk_p_next;
    logic [ADDR_W-1:0] lk_n_reg, lk_n_next;
    logic              pfree_reg, pfree_next;
    logic              nfree_reg, nfree_next;
    logic [ADDR_W-1:0] res_reg, res_next;
    status_t           status_reg, status_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    status_t           out_status_reg, out_status_next;

    logic [ADDR_W-1:0] mem_baddr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wdata;
    logic [16:0]       mem_idx;
    logic              mem_inr;
    logic [ADDR_W-1:0] ram_q;
    logic [ADDR_W-1:0] rd_data;
    logic [ADDR_W-1:0] rd_size;
    logic [SIZE_W-1:0] ext;
    logic [SIZE_W-1:0] rs31;
    logic [ADDR_W+1:0] diff;
    logic [ADDR_W-1:0] init_val;

    assign rd_data = oob_reg ? '0 : ram_q;
    assign rd_size = size_of(rd_data);
    assign ext = (asize_reg > SIZE_W'(GROW_MIN)) ? asize_reg : SIZE_W'(GROW_MIN);
    assign rs31 = {1'b0, req.req_size} + SIZE_W'(31);
    assign diff = {2'b00, rd_size} - {1'b0, asize_reg};
    assign mem_idx = mem_baddr[ADDR_W-1:3];
    assign mem_inr = ({1'b0, mem_idx} < 18'(MEM_DEPTH));
    assign oob_next = !mem_inr;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.result_addr = out_addr_reg;
    assign rsp.status = out_status_reg;

    sfla_ram #(
        .WIDTH(ADDR_W),
        .DEPTH(MEM_DEPTH)
    ) u_heap_ram (
        .clk  (clk),
        .we   (mem_we && mem_inr),
        .waddr(mem_idx[MAW-1:0]),
        .wdata(mem_wdata),
        .raddr(mem_idx[MAW-1:0]),
        .rdata(ram_q)
    );

    always_comb
    begin
        init_val = '0;
        if (init_reg < INIT_BASE)
        begin
            if (init_reg[1:0] == 2'd1 || init_reg[1:0] == 2'd2)
            begin
                init_val = (ADDR_W'(init_reg >> 2) << 5) | 20'd8;
            end
        end
        else if (init_reg == INIT_BASE + IW'(1) || init_reg == INIT_BASE + IW'(2))
        begin
            init_val = PROLOGUE_TAG;
        end
        else if (init_reg == INIT_LAST)
        begin
            init_val = EPILOGUE_TAG;
        end
    end

    // memory access of each step
    always_comb
    begin
        mem_baddr = '0;
        mem_we = 1'b0;
        mem_wdata = '0;
        unique case (state_reg)
            S_INIT:
            begin
                mem_baddr = ADDR_W'(init_reg) << 3;
                mem_we = 1'b1;
                mem_wdata = init_val;
            end
            A_HEAD: mem_baddr = head_of(cls_reg);
            A_LINK: mem_baddr = rd_data - 20'd8;
            A_SIZE: mem_baddr = bp_reg;
            G_EPI:
            begin
                mem_baddr = bp_reg + sz_reg - 20'd8;
                mem_we = 1'b1;
                mem_wdata = EPILOGUE_TAG;
            end
            PL_RS: mem_baddr = bp_reg - 20'd8;
            F_RS: mem_baddr = bp_reg - 20'd8;
            F_RN: mem_baddr = bp_reg - 20'd8;
            F_RP: mem_baddr = bp_reg - 20'd16;
            F_RPA: mem_baddr = bp_reg - rd_size - 20'd8;
            F_RNA: mem_baddr = nxt_reg - 20'd8;
            F_PS: mem_baddr = prv_reg - 20'd8;
            F_NS: mem_baddr = nxt_reg - 20'd8;
            F_AP: mem_baddr = bp_reg - 20'd8;
            ST_WH:
            begin
                mem_baddr = t_bp_reg - 20'd8;
                mem_we = 1'b1;
                mem_wdata = t_val_reg;
            end
            ST_RH: mem_baddr = t_bp_reg - 20'd8;
            ST_WF:
            begin
                mem_baddr = t_bp_reg + rd_size - 20'd16;
                mem_we = 1'b1;
                mem_wdata = t_val_reg;
            end
            UL_RP: mem_baddr = t_bp_reg + 20'd8;
            UL_RN: mem_baddr = t_bp_reg;
            UL_W1:
            begin
                mem_baddr = lk_p_reg;
                mem_we = 1'b1;
                mem_wdata = rd_data;
            end
            UL_W2:
            begin
                mem_baddr = lk_n_reg + 20'd8;
                mem_we = 1'b1;
                mem_wdata = lk_p_reg;
            end
            AP_R: mem_baddr = t_head_reg + 20'd8;
            AP_W1:
            begin
                mem_baddr = t_bp_reg;
                mem_we = 1'b1;
                mem_wdata = t_head_reg;
            end
            AP_W2:
            begin
                mem_baddr = t_bp_reg + 20'd8;
                mem_we = 1'b1;
                mem_wdata = lk_p_reg;
            end
            AP_W3:
            begin
                mem_baddr = lk_p_reg;
                mem_we = 1'b1;
                mem_wdata = t_bp_reg;
            end
            AP_W4:
            begin
                mem_baddr = t_head_reg + 20'd8;
                mem_we = 1'b1;
                mem_wdata = t_bp_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        init_next = init_reg;
        brk_next = brk_reg;
        budget_next = budget_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        bp_next = bp_reg;
        nxt_next = nxt_reg;
        prv_next = prv_reg;
        asize_next = asize_reg;
        sz_next = sz_reg;
        cls_next = cls_reg;
        t_bp_next = t_bp_reg;
        t_val_next = t_val_reg;
        t_head_next = t_head_reg;
        lk_p_next = lk_p_reg;
        lk_n_next = lk_n_reg;
        pfree_next = pfree_reg;
        nfree_next = nfree_reg;
        res_next = res_reg;
        status_next = status_reg;
        out_addr_next = out_addr_reg;
        out_status_next = out_status_reg;
        unique case (state_reg)
            S_INIT:
            begin
                init_next = init_reg + IW'(1);
                if (init_reg == INIT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_next = '0;
                    status_next = STAT_DONE;
                    if (action_t'(req.action) == ACT_ALLOC)
                    begin
                        if (req.req_size == '0)
                        begin
                            status_next = STAT_NULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            asize_next = {rs31[SIZE_W-1:4], 4'b0000};
                            cls_next = class_of({1'b0, rs31[SIZE_W-1:4], 4'b0000});
                            budget_next = BW'(HEAP_WORD_COUNT);
                            state_next = A_HEAD;
                        end
                    end
                    else
                    begin
                        if (req.block_addr == '0)
                        begin
                            status_next = STAT_NULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            bp_next = req.block_addr;
                            state_next = F_RS;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next = res_reg;
                    out_status_next = status_reg;
                    state_next = S_IDLE;
                end
            end
            A_HEAD: state_next = A_LINK;
            A_LINK:
            begin
                if (rd_data == head_of(cls_reg))
                begin
                    if (cls_reg == CLS_LAST)
                    begin
                        state_next = G_CHK;
                    end
                    else
                    begin
                        cls_next = cls_reg + 1'b1;
                        state_next = A_HEAD;
                    end
                end
                else if (budget_reg == '0)
                begin
                    state_next = G_CHK;
                end
                else
                begin
                    budget_next = budget_reg - 1'b1;
                    bp_next = rd_data;
                    state_next = A_SIZE;
                end
            end
            A_SIZE:
            begin
                if ({1'b0, rd_size} >= asize_reg)
                begin
                    t_bp_next = bp_reg;
                    ret_next = PL_RS;
                    state_next = UL_RP;
                end
                else
                begin
                    state_next = A_LINK;
                end
            end
            G_CHK:
            begin
                if (({2'b00, brk_reg} + {1'b0, ext}) > CAP)
                begin
                    status_next = STAT_NO_SPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    bp_next = brk_reg;
                    brk_next = brk_reg + ext[ADDR_W-1:0];
                    sz_next = ext[ADDR_W-1:0];
                    t_bp_next = brk_reg;
                    t_val_next = ext[ADDR_W-1:0];
                    ret_next = G_EPI;
                    state_next = ST_WH;
                end
            end
            G_EPI: state_next = PL_RS;
            PL_RS: state_next = PL_DEC;
            PL_DEC:
            begin
                res_next = bp_reg;
                t_bp_next = bp_reg;
                state_next = ST_WH;
                if (diff >= (ADDR_W+2)'(MIN_SPLIT))
                begin
                    t_val_next = asize_reg[ADDR_W-1:0] | 20'd1;
                    sz_next = diff[ADDR_W-1:0];
                    cls_next = diff[ADDR_W+1] ? CLS_LAST : class_of(diff);
                    ret_next = PL_T2;
                end
                else
                begin
                    t_val_next = rd_size | 20'd1;
                    ret_next = S_DONE;
                end
            end
            PL_T2:
            begin
                t_bp_next = bp_reg + asize_reg[ADDR_W-1:0];
                t_val_next = sz_reg;
                ret_next = PL_AP;
                state_next = ST_WH;
            end
            PL_AP:
            begin
                t_head_next = head_of(cls_reg);
                t_bp_next = bp_reg + asize_reg[ADDR_W-1:0];
                ret_next = S_DONE;
                state_next = AP_R;
            end
            F_RS: state_next = F_ST;
            F_ST:
            begin
                t_bp_next = bp_reg;
                t_val_next = rd_size;
                ret_next = F_RN;
                state_next = ST_WH;
            end
            F_RN: state_next = F_RP;
            F_RP:
            begin
                nxt_next = bp_reg + rd_size;
                sz_next = rd_size;
                state_next = F_RPA;
            end
            F_RPA:
            begin
                prv_next = bp_reg - rd_size;
                state_next = F_RNA;
            end
            F_RNA:
            begin
                pfree_next = !rd_data[0];
                state_next = F_DEC;
            end
            F_DEC:
            begin
                nfree_next = !rd_data[0];
                if (pfree_reg)
                begin
                    t_bp_next = prv_reg;
                    ret_next = F_PS;
                    state_next = UL_RP;
                end
                else
                begin
                    state_next = F_NX;
                end
            end
            F_PS: state_next = F_PS2;
            F_PS2:
            begin
                sz_next = sz_reg + rd_size;
                bp_next = prv_reg;
                state_next = F_NX;
            end
            F_NX:
            begin
                if (nfree_reg)
                begin
                    t_bp_next = nxt_reg;
                    ret_next = F_NS;
                    state_next = UL_RP;
                end
                else
                begin
                    state_next = F_WR;
                end
            end
            F_NS: state_next = F_NS2;
            F_NS2:
            begin
                sz_next = sz_reg + rd_size;
                state_next = F_WR;
            end
            F_WR:
            begin
                t_bp_next = bp_reg;
                t_val_next = sz_reg;
                ret_next = F_AP;
                state_next = ST_WH;
            end
            F_AP: state_next = F_AP2;
            F_AP2:
            begin
                t_head_next = head_of(class_of({2'b00, rd_size}));
                t_bp_next = bp_reg;
                ret_next = S_DONE;
                state_next = AP_R;
            end
            ST_WH: state_next = ST_RH;
            ST_RH: state_next = ST_WF;
            ST_WF: state_next = ret_reg;
            UL_RP: state_next = UL_RN;
            UL_RN:
            begin
                lk_p_next = rd_data;
                state_next = UL_W1;
            end
            UL_W1:
            begin
                lk_n_next = rd_data;
                state_next = UL_W2;
            end
            UL_W2: state_next = ret_reg;
            AP_R: state_next = AP_W1;
            AP_W1:
            begin
                lk_p_next = rd_data;
                state_next = AP_W2;
            end
            AP_W2: state_next = AP_W3;
            AP_W3: state_next = AP_W4;
            AP_W4: state_next = ret_reg;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            ret_reg <= S_IDLE;
            init_reg <= '0;
            brk_reg <= BRK_INIT;
            budget_reg <= '0;
            out_valid_reg <= 1'b0;
            oob_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            init_reg <= init_next;
            brk_reg <= brk_next;
            budget_reg <= budget_next;
            out_valid_reg <= out_valid_next;
            oob_reg <= oob_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bp_reg <= bp_next;
        nxt_reg <= nxt_next;
        prv_reg <= prv_next;
        asize_reg <= asize_next;
        sz_reg <= sz_next;
        cls_reg <= cls_next;
        t_bp_reg <= t_bp_next;
        t_val_reg <= t_val_next;
        t_head_reg <= t_head_next;
        lk_p_reg <= lk_p_next;
        lk_n_reg <= lk_n_next;
        pfree_reg <= pfree_next;
        nfree_reg <= nfree_next;
        res_reg <= res_next;
        status_reg <= status_next;
        out_addr_reg <= out_addr_next;
        out_status_reg <= out_status_next;
    end
endmodule

// File: rtl/sfla_checker.sv
`include "segregated_free_list_allocator_core_macros.svh"

module sfla_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     in_action,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [sfla_pkg::ADDR_W-1:0] out_addr,
    input logic [sfla_pkg::STAT_W-1:0] out_status
);
    import sfla_pkg::*;

    logic [1:0] pend_reg, pend_next;
    action_t    act_reg, act_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
        act_next = in_acc ? action_t'(in_action) : act_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            act_reg <= ACT_ALLOC;
        end
        else
        begin
            pend_reg <= pend_next;
            act_reg <= act_next;
        end
    end

    `SFLA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
    `SFLA_ASSERT_IMP(a_out_owed, out_valid, pend_reg != 2'd0)
    `SFLA_ASSERT_IMP(a_fail_null, out_valid && out_status != STAT_DONE, out_addr == '0)
    `SFLA_ASSERT_IMP(a_free_null, out_valid && pend_reg == 2'd1 && act_reg == ACT_FREE, out_addr == '0)
endmodule

bind segregated_free_list_allocator_core sfla_checker u_sfla_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_action (req.action),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_addr  (rsp.result_addr),
    .out_status(rsp.status)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import sfla_pkg::*;

    localparam int HEAP_WORDS = 65536;
    localparam int CLASSES = 14;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        action_t           act;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] addr;
    } heap_op_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        status_t           st;
    } heap_rsp_t;

    logic clk;
    logic rst_n;

    sfla_req_if req ();
    sfla_rsp_if rsp ();

    segregated_free_list_allocator_core #(
        .HEAP_WORD_COUNT(HEAP_WORDS),
        .CLASS_COUNT(CLASSES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    logic [ADDR_W-1:0] heap_mem [HEAP_WORDS];
    int unsigned       heap_top;
    heap_op_t          pending_ops[$];
    heap_rsp_t         expected_rsps[$];
    int unsigned       live_blocks[$];
    int                total_ops;
    int                ops_sent;
    int                rsps_seen;
    int                errors;
    int                hold_cnt;
    bit                hold_done;
    int                idle_cnt;

    function automatic int unsigned hrd(int unsigned a);
        int unsigned idx;
        idx = (a & 32'hFFFFF) >> 3;
        if (idx >= HEAP_WORDS)
        begin
            return 0;
        end
        return heap_mem[idx];
    endfunction

    function automatic void hwr(int unsigned a, int unsigned v);
        int unsigned idx;
        idx = (a & 32'hFFFFF) >> 3;
        if (idx < HEAP_WORDS)
        begin
            heap_mem[idx] = v[ADDR_W-1:0];
        end
    endfunction

    function automatic int unsigned bsize(int unsigned bp);
        return hrd(bp - 8) & ~32'd15;
    endfunction

    function automatic void put_tags(int unsigned bp, int unsigned sz, int unsigned al);
        hwr(bp - 8, sz | al);
        hwr(bp + bsize(bp) - 16, sz | al);
    endfunction

    function automatic int unsigned size_class(int unsigned sz);
        int unsigned lim;
        int unsigned i;
        lim = 64;
        i = 0;
        while (sz > lim && i < CLASSES - 1)
        begin
            i++;
            lim = lim << 1;
        end
        return i;
    endfunction

    function automatic int unsigned list_head(int unsigned i);
        return i * 32 + 8;
    endfunction

    function automatic void unlink_block(int unsigned bp);
        int unsigned p;
        int unsigned n;
        p = hrd(bp + 8);
        n = hrd(bp);
        hwr(p, n);
        hwr(n + 8, p);
    endfunction

    function automatic void append_block(int unsigned head, int unsigned bp);
        int unsigned last;
        last = hrd(head + 8);
        hwr(bp, head);
        hwr(bp + 8, last);
        hwr(last, bp);
        hwr(head + 8, bp);
    endfunction

    function automatic void carve_block(int unsigned bp, int unsigned asize);
        int unsigned full;
        int unsigned rest;
        full = bsize(bp);
        rest = full - asize;
        if (rest >= MIN_SPLIT)
        begin
            put_tags(bp, asize, 1);
            put_tags(bp + asize, rest, 0);
            append_block(list_head(size_class(rest)), bp + asize);
        end
        else
        begin
            put_tags(bp, full, 1);
        end
    endfunction

    function automatic bit first_fit(int unsigned asize, output int unsigned found);
        int unsigned budget;
        int unsigned head;
        int unsigned bp;
        budget = HEAP_WORDS;
        found = 0;
        for (int unsigned i = size_class(asize); i < CLASSES; i++)
        begin
            head = list_head(i);
            bp = hrd(head);
            while (bp != head)
            begin
                if (budget == 0)
                begin
                    return 0;
                end
                budget--;
                if (asize <= bsize(bp))
                begin
                    found = bp;
                    return 1;
                end
                bp = hrd(bp);
            end
        end
        return 0;
    endfunction

    function automatic void release_block(int unsigned bp);
        int unsigned nxt;
        int unsigned prv;
        int unsigned sz;
        bit          prv_free;
        bit          nxt_free;
        put_tags(bp, bsize(bp), 0);
        nxt = bp + bsize(bp);
        prv = bp - (hrd(bp - 16) & ~32'd15);
        prv_free = (hrd(prv - 8) & 1) == 0;
        nxt_free = (hrd(nxt - 8) & 1) == 0;
        sz = bsize(bp);
        if (prv_free)
        begin
            unlink_block(prv);
            sz += bsize(prv);
            bp = prv;
        end
        if (nxt_free)
        begin
            unlink_block(nxt);
            sz += bsize(nxt);
        end
        hwr(bp - 8, sz);
        hwr(bp + bsize(bp) - 16, sz);
        append_block(list_head(size_class(bsize(bp))), bp);
    endfunction

    function automatic void heap_init();
        int unsigned bp;
        int unsigned base;
        foreach (heap_mem[i])
        begin
            heap_mem[i] = '0;
        end
        for (int unsigned i = 0; i < CLASSES; i++)
        begin
            bp = list_head(i);
            hwr(bp, bp);
            hwr(bp + 8, bp);
            hwr(bp - 8, 0);
            if (i != 0)
            begin
                hwr(bp - 16, 0);
            end
        end
        base = CLASSES * 32;
        hwr(base, 0);
        hwr(base + 8, PROLOGUE_TAG);
        hwr(base + 16, PROLOGUE_TAG);
        hwr(base + 24, EPILOGUE_TAG);
        heap_top = base + 32;
    endfunction

    function automatic heap_rsp_t heap_apply(heap_op_t op);
        heap_rsp_t   r;
        int unsigned asize;
        int unsigned ext;
        int unsigned bp;
        int unsigned cap;
        r.addr = '0;
        r.st = STAT_DONE;
        if (op.act == ACT_ALLOC)
        begin
            if (op.size == 0)
            begin
                r.st = STAT_NULL;
            end
            else
            begin
                asize = 16 * ((int'(op.size) + 31) / 16);
                if (first_fit(asize, bp))
                begin
                    unlink_block(bp);
                    carve_block(bp, asize);
                    r.addr = bp[ADDR_W-1:0];
                end
                else
                begin
                    ext = asize > GROW_MIN ? asize : GROW_MIN;
                    cap = HEAP_WORDS * 8;
                    if (cap > CAP_LIMIT)
                    begin
                        cap = CAP_LIMIT;
                    end
                    if (heap_top + ext > cap)
                    begin
                        r.st = STAT_NO_SPACE;
                    end
                    else
                    begin
                        bp = heap_top;
                        heap_top += ext;
                        hwr(bp - 8, ext);
                        hwr(bp + bsize(bp) - 16, ext);
                        hwr(bp + ext - 8, EPILOGUE_TAG);
                        carve_block(bp, asize);
                        r.addr = bp[ADDR_W-1:0];
                    end
                end
            end
        end
        else if (op.addr == 0)
        begin
            r.st = STAT_NULL;
        end
        else
        begin
            release_block(op.addr);
        end
        return r;
    endfunction

    function automatic void queue_op(action_t act, int unsigned sz, int unsigned ad);
        heap_op_t  op;
        heap_rsp_t r;
        op.act = act;
        op.size = sz[ADDR_W-1:0];
        op.addr = ad[ADDR_W-1:0];
        r = heap_apply(op);
        if (act == ACT_ALLOC && r.st == STAT_DONE)
        begin
            live_blocks.push_back(r.addr);
        end
        pending_ops.push_back(op);
        expected_rsps.push_back(r);
    endfunction

    function automatic void free_live(int unsigned k);
        int unsigned a;
        a = live_blocks[k];
        live_blocks.delete(k);
        queue_op(ACT_FREE, 0, (a & ~32'd7) | $urandom_range(7));
    endfunction

    function automatic int unsigned rand_size();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 65)
        begin
            return $urandom_range(256, 1);
        end
        else if (p < 90)
        begin
            return $urandom_range(4096, 257);
        end
        else if (p < 99)
        begin
            return $urandom_range(65536, 4097);
        end
        return $urandom_range(524288, 65537);
    endfunction

    function automatic int sender_idle_pct();
        if (ops_sent < total_ops / 3)
        begin
            return 34;
        end
        else if (ops_sent < 2 * total_ops / 3)
        begin
            return 60;
        end
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (rsps_seen < total_ops / 3)
        begin
            return 60;
        end
        else if (rsps_seen < 2 * total_ops / 3)
        begin
            return 34;
        end
        return 0;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.action = ACT_ALLOC;
        req.req_size = '0;
        req.block_addr = '0;
        rsp.ready = 1'b0;
        errors = 0;
        ops_sent = 0;
        rsps_seen = 0;
        hold_cnt = 0;
        hold_done = 1'b0;
        idle_cnt = 0;
        rst_n = 1'b0;
        heap_init();

        queue_op(ACT_ALLOC, 0, 0);
        queue_op(ACT_FREE, 0, 0);
        queue_op(ACT_ALLOC, 1, 0);
        queue_op(ACT_ALLOC, 524288, 0);
        queue_op(ACT_ALLOC, 400000, 0);
        queue_op(ACT_ALLOC, 524288, 0);
        queue_op(ACT_ALLOC, 16, 0);
        queue_op(ACT_ALLOC, 100, 0);
        queue_op(ACT_ALLOC, 17, 0);
        queue_op(ACT_ALLOC, 200, 0);
        queue_op(ACT_ALLOC, 1000, 0);
        queue_op(ACT_ALLOC, 20'hFFFFF & 20'h7FFFF, 0);
        free_live(2);
        free_live(1);
        free_live(0);
        queue_op(ACT_ALLOC, 48, 0);
        free_live(2);
        free_live(live_blocks.size() - 1);
        queue_op(ACT_ALLOC, 5000, 0);
        queue_op(ACT_ALLOC, 130000, 0);
        while (live_blocks.size() > 0)
        begin
            free_live($urandom_range(live_blocks.size() - 1));
        end

        while (pending_ops.size() < 1770)
        begin
            int unsigned p;
            p = $urandom_range(99);
            if (p < 3)
            begin
                queue_op(p[0] ? ACT_FREE : ACT_ALLOC, 0, 0);
            end
            else if (live_blocks.size() > 0 && (p < 45 || live_blocks.size() > 80))
            begin
                free_live($urandom_range(live_blocks.size() - 1));
            end
            else
            begin
                queue_op(ACT_ALLOC, rand_size(), 0);
            end
        end
        total_ops = pending_ops.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && expected_rsps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                ops_sent++;
            end
            if (!req.valid || req.ready)
            begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    heap_op_t op;
                    op = pending_ops.pop_front();
                    req.valid <= 1'b1;
                    req.action <= op.act;
                    req.req_size <= op.size;
                    req.block_addr <= op.addr;
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                rsps_seen++;
                if (expected_rsps.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word addr=%0d status=%0d",
                             $realtime, rsp.result_addr, rsp.status);
                end
                else
                begin
                    heap_rsp_t e;
                    e = expected_rsps.pop_front();
                    if (rsp.result_addr !== e.addr)
                    begin
                        errors++;
                        $display("%0t: result_addr expected %0d actual %0d",
                                 $realtime, e.addr, rsp.result_addr);
                    end
                    if (rsp.status !== e.st)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, e.st, rsp.status);
                    end
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                rsp.ready <= 1'b0;
            end
            else if (!hold_done && rsps_seen >= 150)
            begin
                hold_done <= 1'b1;
                hold_cnt <= HOLD_CYCLES;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= $urandom_range(99) >= receiver_idle_pct();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            begin
                idle_cnt <= 0;
            end
            else if (idle_cnt >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                idle_cnt <= idle_cnt + 1;
            end
        end
    end

endmodule
